### rtl/core/msr_pkg.sv
// Shared types for the motor soft-start ramp block.
package msr_pkg;

  // Field widths
  localparam int DutyW     = 7;
  localparam int IntervalW = 16;
  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 16;
  localparam int TdataW    = 16;

  // Configuration register indexes
  typedef enum logic [CfgIndexW-1:0] {
    CFG_UPDATE_INTERVAL = 2'd0,
    CFG_RAMP_STEP       = 2'd1,
    CFG_MIN_DUTY        = 2'd2
  } cfg_index_t;

  // Reset values of the configuration registers
  localparam logic [IntervalW-1:0] UpdateIntervalReset = 16'd20;
  localparam logic [DutyW-1:0]     RampStepReset       = 7'd2;
  localparam logic [DutyW-1:0]     MinDutyReset        = 7'd20;

  // Current configuration
  typedef struct packed {
    logic [IntervalW-1:0] update_interval;
    logic [DutyW-1:0]     ramp_step;
    logic [DutyW-1:0]     min_duty;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic [DutyW-1:0] duty_forward;
    logic [DutyW-1:0] duty_reverse;
    logic             light_forward;
  } result_t;

endpackage

### rtl/core/msr_cfg.sv
// Configuration register file of the motor soft-start ramp block.
module msr_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [msr_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [msr_pkg::CfgDataW-1:0]  cfg_wdata,
  output msr_pkg::cfg_t                 cfg
);

  msr_pkg::cfg_index_t idx;

  assign idx = msr_pkg::cfg_index_t'(cfg_index);

  // Register writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.update_interval <= msr_pkg::UpdateIntervalReset;
      cfg.ramp_step       <= msr_pkg::RampStepReset;
      cfg.min_duty        <= msr_pkg::MinDutyReset;
    end else if (cfg_we) begin
      unique case (idx)
        msr_pkg::CFG_UPDATE_INTERVAL: cfg.update_interval <= cfg_wdata[msr_pkg::IntervalW-1:0];
        msr_pkg::CFG_RAMP_STEP:       cfg.ramp_step       <= cfg_wdata[msr_pkg::DutyW-1:0];
        msr_pkg::CFG_MIN_DUTY:        cfg.min_duty        <= cfg_wdata[msr_pkg::DutyW-1:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/msr_core.sv
// Tick counter, ramp state and single-pass update logic.
module msr_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic [msr_pkg::DutyW-1:0] target_forward,
  input  logic [msr_pkg::DutyW-1:0] target_reverse,
  input  msr_pkg::cfg_t             cfg,
  output logic                      upd,
  output msr_pkg::result_t          result
);

  localparam int W  = msr_pkg::DutyW;
  localparam int SW = msr_pkg::DutyW + 3;

  // State registers
  logic [msr_pkg::IntervalW-1:0] tick_count;
  logic [W-1:0] level_forward, level_reverse, drive_forward, drive_reverse;
  logic         reversing, direction_forward;

  logic [msr_pkg::IntervalW-1:0] tick_count_next;
  logic [W-1:0] level_forward_next, level_reverse_next;
  logic [W-1:0] drive_forward_next, drive_reverse_next;
  logic         reversing_next, direction_forward_next;

  logic [msr_pkg::IntervalW:0] tick_inc;
  logic         stop;
  logic [W-1:0] lf_a, lr_a, df_a, dr_a, lf_r, lr_r;
  logic         rev_a, skip;

  // Widen an unsigned duty to a signed working value.
  function automatic logic signed [SW-1:0] wide(input logic [W-1:0] v);
    wide = $signed({3'b000, v});
  endfunction

  // Lower a level by the step; at or below the minimum it snaps to zero.
  function automatic logic [W-1:0] brake(input logic [W-1:0] lvl, input logic [W-1:0] step,
                                         input logic [W-1:0] mind);
    logic signed [SW-1:0] d;
    d = wide(lvl) - wide(step);
    if (d <= wide(mind)) brake = '0;
    else                 brake = d[W-1:0];
  endfunction

  // Move one level a step toward its target, or brake it on a full stop.
  function automatic logic [W-1:0] ramp(input logic [W-1:0] lvl, input logic [W-1:0] tgt,
                                        input logic stp, input logic [W-1:0] step,
                                        input logic [W-1:0] mind);
    logic signed [SW-1:0] s;
    s = wide(lvl);
    if (!stp && tgt != '0) begin
      if (lvl < tgt) begin
        s = wide(lvl) + wide(step);
        if (s <= wide(mind)) s = wide(mind);
        if (s >= wide(tgt))  s = wide(tgt);
      end else if (lvl > tgt) begin
        s = wide(lvl) - wide(step);
        if (s < wide(tgt)) s = wide(tgt);
      end
    end else if (stp && lvl >= mind) begin
      s = wide(lvl) - wide(step);
      if (s <= wide(mind)) s = '0;
    end
    ramp = s[W-1:0];
  endfunction

  // Interval counting: an update happens when the count reaches the interval.
  assign tick_inc        = {1'b0, tick_count} + 1'b1;
  assign upd             = tick_inc >= {1'b0, cfg.update_interval};
  assign tick_count_next = upd ? '0 : tick_inc[msr_pkg::IntervalW-1:0];

  assign stop = (target_forward == '0) && (target_reverse == '0);

  // Reversal braking, then the ramp stage and drive selection.
  always_comb begin
    lf_a  = level_forward;
    lr_a  = level_reverse;
    df_a  = drive_forward;
    dr_a  = drive_reverse;
    skip  = 1'b0;
    rev_a = reversing || (level_forward != '0 && target_reverse != '0)
                      || (level_reverse != '0 && target_forward != '0);
    if (rev_a) begin
      if (level_forward != '0) begin
        lf_a  = brake(level_forward, cfg.ramp_step, cfg.min_duty);
        rev_a = lf_a != '0;
        df_a  = lf_a;
      end else if (level_reverse != '0) begin
        lr_a  = brake(level_reverse, cfg.ramp_step, cfg.min_duty);
        rev_a = lr_a != '0;
        dr_a  = lr_a;
      end
      if (lf_a == '0 && lr_a == '0) begin
        if (target_forward != '0)      dr_a = '0;
        else if (target_reverse != '0) df_a = '0;
        rev_a = 1'b0;
        skip  = 1'b1;
      end
    end

    lf_r = ramp(lf_a, target_forward, stop, cfg.ramp_step, cfg.min_duty);
    lr_r = ramp(lr_a, target_reverse, stop, cfg.ramp_step, cfg.min_duty);

    level_forward_next     = lf_a;
    level_reverse_next     = lr_a;
    drive_forward_next     = df_a;
    drive_reverse_next     = dr_a;
    reversing_next         = rev_a;
    direction_forward_next = direction_forward;
    if (!skip && !rev_a) begin
      level_forward_next = lf_r;
      level_reverse_next = lr_r;
      if (lf_r != '0) begin
        drive_forward_next     = lf_r;
        drive_reverse_next     = '0;
        direction_forward_next = 1'b1;
      end else if (lr_r != '0) begin
        drive_forward_next     = '0;
        drive_reverse_next     = lr_r;
        direction_forward_next = 1'b0;
      end else begin
        drive_forward_next     = '0;
        drive_reverse_next     = '0;
        direction_forward_next = 1'b1;
      end
    end
  end

  assign result.duty_forward  = drive_forward_next;
  assign result.duty_reverse  = drive_reverse_next;
  assign result.light_forward = direction_forward_next;

  // State update for each processed item.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count        <= '0;
      level_forward     <= '0;
      level_reverse     <= '0;
      reversing         <= 1'b1;
      drive_forward     <= '0;
      drive_reverse     <= '0;
      direction_forward <= 1'b0;
    end else if (en) begin
      tick_count <= tick_count_next;
      if (upd) begin
        level_forward     <= level_forward_next;
        level_reverse     <= level_reverse_next;
        reversing         <= reversing_next;
        drive_forward     <= drive_forward_next;
        drive_reverse     <= drive_reverse_next;
        direction_forward <= direction_forward_next;
      end
    end
  end

  // An update item restarts the interval count.
  a_upd_clears_count: assert property (@(posedge clk) disable iff (rst)
    en && upd |=> tick_count == '0)
    else $error("tick count not cleared on an update item");

  // An item without an update leaves the ramp state alone.
  a_idle_tick_holds: assert property (@(posedge clk) disable iff (rst)
    en && !upd |=> $stable(level_forward) && $stable(level_reverse) && $stable(reversing))
    else $error("ramp state changed on a tick without update");

  // An item without an update advances the count by one.
  a_count_advances: assert property (@(posedge clk) disable iff (rst)
    en && !upd |=> tick_count == $past(tick_count) + 1'b1)
    else $error("tick count did not advance");

endmodule

### rtl/core/motor_soft_start_ramp.sv
// An accepted item waits in the input register; its result (if any) is then registered
// in the result register, from which the receiver takes it.
// Throughput: one item per cycle unless stalled; results come only on update ticks.
// The input register and the result register form a two-stage pipeline that
// stalls only while a result waits on m_axis_tready.
// Reset (rst, synchronous): configuration returns to interval 20, step 2,
// minimum 20; levels and drives clear and the reversal flag is set.
module motor_soft_start_ramp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [msr_pkg::TdataW-1:0]    s_axis_tdata,  // target_forward, target_reverse
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [msr_pkg::TdataW-1:0]    m_axis_tdata,  // duty_forward, duty_reverse,
                                                       // light_forward
  input  logic                          cfg_we,
  input  logic [msr_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [msr_pkg::CfgDataW-1:0]  cfg_wdata
);

  localparam int W = msr_pkg::DutyW;

  msr_pkg::cfg_t    cfg;
  msr_pkg::result_t result;
  msr_pkg::result_t out_reg;

  logic         in_valid;
  logic [W-1:0] in_forward, in_reverse;
  logic         advance, en, upd, s_accept;

  msr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Pipeline control: everything moves unless a result is stuck downstream.
  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign en            = in_valid && advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (advance) begin
      in_valid <= s_accept;
    end else if (!in_valid) begin
      in_valid <= s_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_forward <= s_axis_tdata[W-1:0];
      in_reverse <= s_axis_tdata[2*W-1:W];
    end
  end

  msr_core u_core (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .target_forward (in_forward),
    .target_reverse (in_reverse),
    .cfg            (cfg),
    .upd            (upd),
    .result         (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= en && upd;
    end
  end

  always_ff @(posedge clk) begin
    if (en && upd) begin
      out_reg <= result;
    end
  end

  assign m_axis_tdata = {1'b0, out_reg.light_forward, out_reg.duty_reverse,
                         out_reg.duty_forward};

  // A tick without an update never produces a result item.
  a_no_result_without_update: assert property (@(posedge clk) disable iff (rst)
    en && !upd |=> !m_axis_tvalid)
    else $error("result item produced without an update");

  // A new item never overwrites a held input item.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(s_accept && in_valid && !advance))
    else $error("input register overwritten while stalled");

  // An update item always shows up as a result.
  a_update_gives_result: assert property (@(posedge clk) disable iff (rst)
    en && upd |=> m_axis_tvalid)
    else $error("update item lost its result");

endmodule
